// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the decoder RTL
// Concurrent checks sampled on the rising clock, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every clock while reset is low.
`define XDRF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds while reset is low.
`define XDRF_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/xdrf_pkg.sv =====
// ----------------------------------------------------------------------------
// xdrf_pkg
// Shared constants, types and helpers of the XOR delta run frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xdrf_pkg;

   // Bitmap geometry
   localparam int BITMAP_DEPTH = 192;
   localparam int ADDR_W       = (BITMAP_DEPTH > 1) ? $clog2(BITMAP_DEPTH) : 1;

   // Stream word layout
   localparam int WORD_W       = 16;
   localparam int COUNT_W      = 15;
   localparam int RUN_FLAG_BIT = 15;
   localparam int INDEX_W      = 8;

   // Queue sizes
   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH  = 2;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   // Operation codes of an input word
   localparam logic OP_STREAM = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Parse phase
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_TOKEN  = 2'd1,
      PH_RUN    = 2'd2
   } phase_type;

   // Classified word handed from the parser to the bitmap engine
   typedef struct packed {
      logic              clear;
      logic              write;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
      logic              frame_end;
      logic              overrun;
   } cmd_type;

   // Finished result word
   typedef struct packed {
      logic               wrote;
      logic [INDEX_W-1:0] word_slot;
      logic [WORD_W-1:0]  word_value;
      logic               frame_end;
      logic               overrun;
   } rsp_type;

   // Add with saturation at the top of the 16-bit range
   function automatic logic [WORD_W-1:0] sat_add16(logic [WORD_W-1:0] a,
                                                   logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
   endfunction

endpackage

// ===== rtl/xdrf_front.sv =====
// ----------------------------------------------------------------------------
// xdrf_front
// Frame parser: tracks header, token and run phases, the bitmap position
// and the frame and run counters, and turns each word into a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xdrf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             q_full,
   input  logic             op,
   input  logic [15:0]      data_word,
   output logic             cmd_push,
   output xdrf_pkg::cmd_type cmd
);
   import xdrf_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [WORD_W-1:0]   position_ff, position_in;
   logic [WORD_W-1:0]   frame_left_ff, frame_left_in;
   logic [COUNT_W-1:0]  run_left_ff, run_left_in;

   logic [WORD_W-1:0]   frame_dec;
   logic [COUNT_W-1:0]  run_dec;
   logic [COUNT_W-1:0]  count;
   logic                in_frame;
   logic                in_range;

   // Take a word whenever the command queue has room
   assign cmd_push  = push && !q_full;

   assign frame_dec = frame_left_ff - WORD_W'(1);
   assign run_dec   = run_left_ff - COUNT_W'(1);
   assign count     = data_word[COUNT_W-1:0];
   assign in_frame  = (phase_ff == PH_TOKEN) || (phase_ff == PH_RUN);
   assign in_range  = position_ff < WORD_W'(BITMAP_DEPTH);

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         position_ff   <= '0;
         frame_left_ff <= '0;
         run_left_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         frame_left_ff <= frame_left_in;
         run_left_ff   <= run_left_in;
      end
   end

   // Classify the word and advance the parse state
   always_comb begin
      phase_in      = phase_ff;
      position_in   = position_ff;
      frame_left_in = frame_left_ff;
      run_left_in   = run_left_ff;
      cmd           = '0;
      if (cmd_push) begin
         if (op == OP_CLEAR) begin
            phase_in      = PH_HEADER;
            position_in   = '0;
            frame_left_in = '0;
            run_left_in   = '0;
            cmd.clear     = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_TOKEN: begin
                  frame_left_in = frame_dec;
                  if (data_word[RUN_FLAG_BIT]) begin
                     run_left_in = count;
                     if (count != '0) begin
                        phase_in = PH_RUN;
                     end
                  end else begin
                     position_in = sat_add16(position_ff, {1'b0, count});
                  end
               end
               PH_RUN: begin
                  frame_left_in = frame_dec;
                  run_left_in   = run_dec;
                  if (in_range) begin
                     cmd.write = 1'b1;
                     cmd.addr  = position_ff[ADDR_W-1:0];
                     cmd.data  = data_word;
                  end else begin
                     cmd.overrun = 1'b1;
                  end
                  position_in = sat_add16(position_ff, WORD_W'(1));
                  if (run_dec == '0) begin
                     phase_in = PH_TOKEN;
                  end
               end
               default: begin
                  // header word, also taken in the unused phase code
                  frame_left_in = data_word;
                  position_in   = '0;
                  run_left_in   = '0;
                  if (data_word == '0) begin
                     cmd.frame_end = 1'b1;
                     phase_in      = PH_HEADER;
                  end else begin
                     phase_in = PH_TOKEN;
                  end
               end
            endcase
            // close the frame on its last word, dropping any open run
            if (in_frame && (frame_dec == '0)) begin
               cmd.frame_end = 1'b1;
               if (phase_in == PH_RUN) begin
                  cmd.overrun = 1'b1;
               end
               run_left_in = '0;
               phase_in    = PH_HEADER;
            end
         end
      end
   end

   `XDRF_ASSERT(a_frame_end_to_header, clock, reset, (cmd_push && cmd.frame_end) |=> (phase_ff == PH_HEADER), "frame end did not return parser to header")
   `XDRF_ASSERT(a_write_only_in_run, clock, reset, (cmd_push && cmd.write) |-> (phase_ff == PH_RUN), "bitmap write issued outside a run")

endmodule

// ===== rtl/xdrf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// xdrf_cmd_queue
// Short command queue between the parser and the bitmap engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xdrf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xdrf_pkg::cmd_type wr_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output xdrf_pkg::cmd_type rd_cmd
);
   import xdrf_pkg::*;

   cmd_type                entries_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = count_ff == CMD_CNT_W'(CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_cmd  = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ===== rtl/xdrf_back.sv =====
// ----------------------------------------------------------------------------
// xdrf_back
// Bitmap engine: reads the bitmap word, XORs the run word in, writes it
// back with forwarding, and queues the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xdrf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  xdrf_pkg::cmd_type q_cmd,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output xdrf_pkg::rsp_type rsp
);
   import xdrf_pkg::*;

   logic [WORD_W-1:0]      bitmap_mem [BITMAP_DEPTH];
   logic [BITMAP_DEPTH-1:0] vld_ff;

   logic                   s2_valid_ff;
   cmd_type                s2_cmd_ff;
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   rd_vld_ff;
   logic                   fwd_ff;
   logic [WORD_W-1:0]      fwd_val_ff;

   logic                   issue, s2_fire, hit;
   logic [WORD_W-1:0]      old_val, new_val;
   rsp_type                s2_rsp;

   rsp_type                out_q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   out_wr_ff, out_rd_ff;
   logic [RSP_CNT_W-1:0]   out_cnt_ff;
   logic                   out_full, out_pop;

   assign out_full = out_cnt_ff == RSP_CNT_W'(RSP_DEPTH);
   assign empty    = out_cnt_ff == '0;
   assign out_pop  = pop && !empty;
   assign rsp      = out_q_ff[out_rd_ff];

   // Stage hand-off: issue a read when the write stage is empty or frees this cycle
   assign s2_fire = s2_valid_ff && !out_full;
   assign issue   = !q_empty && (!s2_valid_ff || s2_fire);
   assign q_pop   = issue;

   // Forward a same-cycle write or clear to the word being read
   assign hit = s2_valid_ff &&
                (s2_cmd_ff.clear || (s2_cmd_ff.write && (s2_cmd_ff.addr == q_cmd.addr)));

   // Merge forwarded, stored and never-written data, then XOR
   assign old_val = fwd_ff ? fwd_val_ff : (rd_vld_ff ? rd_data_ff : '0);
   assign new_val = old_val ^ s2_cmd_ff.data;

   // Build the result word
   always_comb begin
      s2_rsp            = '0;
      s2_rsp.wrote      = s2_cmd_ff.write;
      s2_rsp.frame_end  = s2_cmd_ff.frame_end;
      s2_rsp.overrun    = s2_cmd_ff.overrun;
      if (s2_cmd_ff.write) begin
         s2_rsp.word_slot  = INDEX_W'(s2_cmd_ff.addr);
         s2_rsp.word_value = new_val;
      end
   end

   // Track the write stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (issue) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_fire) begin
         s2_valid_ff <= 1'b0;
      end
   end

   // Capture the issued command and forwarding info
   always_ff @(posedge clock) begin
      if (issue) begin
         s2_cmd_ff  <= q_cmd;
         fwd_ff     <= hit;
         fwd_val_ff <= s2_cmd_ff.clear ? '0 : new_val;
         rd_vld_ff  <= vld_ff[q_cmd.addr];
      end
   end

   // Bitmap storage: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (s2_fire && s2_cmd_ff.write) begin
         bitmap_mem[s2_cmd_ff.addr] <= new_val;
      end
      if (issue) begin
         rd_data_ff <= bitmap_mem[q_cmd.addr];
      end
   end

   // Mark written entries; clear drops them all at once
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (s2_fire && s2_cmd_ff.clear) begin
         vld_ff <= '0;
      end else if (s2_fire && s2_cmd_ff.write) begin
         vld_ff[s2_cmd_ff.addr] <= 1'b1;
      end
   end

   // Result queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (s2_fire) begin
            out_wr_ff <= (out_wr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : out_wr_ff + RSP_PTR_W'(1);
         end
         if (out_pop) begin
            out_rd_ff <= (out_rd_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : out_rd_ff + RSP_PTR_W'(1);
         end
         if (s2_fire && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + RSP_CNT_W'(1);
         end else if (out_pop && !s2_fire) begin
            out_cnt_ff <= out_cnt_ff - RSP_CNT_W'(1);
         end
      end
   end

   // Store the finished word
   always_ff @(posedge clock) begin
      if (s2_fire) begin
         out_q_ff[out_wr_ff] <= s2_rsp;
      end
   end

   `XDRF_ASSERT(a_issue_frees_stage, clock, reset, (issue && s2_valid_ff) |-> s2_fire, "read issued while write stage stalled")
   `XDRF_ASSERT(a_write_in_range, clock, reset, (s2_valid_ff && s2_cmd_ff.write) |-> ({1'b0, s2_cmd_ff.addr} < (ADDR_W + 1)'(BITMAP_DEPTH)), "bitmap write past depth")
   `XDRF_ASSERT(a_clear_drops_valid, clock, reset, (s2_fire && s2_cmd_ff.clear) |=> (vld_ff == '0), "clear left bitmap entries valid")

endmodule

// ===== rtl/xor_delta_run_frame_decoder_unit.sv =====
// A word accepted into the command queue moves on to the write stage and then
// into the result queue. Throughput: one word per cycle while neither queue is
// full, bounded by the single bitmap read-modify-write, which write-to-read
// forwarding keeps at one per cycle. Reset: synchronous; it clears the parser,
// both queues and the bitmap valid bits, after which every bitmap word reads as zero.
// ----------------------------------------------------------------------------
// xor_delta_run_frame_decoder_unit
// Top level: parser front, command queue and bitmap engine back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_delta_run_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [15:0] req_data_word,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_wrote,
   output logic [7:0]  rsp_word_slot,
   output logic [15:0] rsp_word_value,
   output logic        rsp_frame_end,
   output logic        rsp_overrun
);
   import xdrf_pkg::*;

   logic    cmd_push, q_full, q_empty, q_pop;
   cmd_type cmd_wr, cmd_rd;
   rsp_type rsp;

   assign full = q_full;

   xdrf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .q_full    (q_full),
      .op        (req_op),
      .data_word (req_data_word),
      .cmd_push  (cmd_push),
      .cmd       (cmd_wr)
   );

   xdrf_cmd_queue u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_cmd (cmd_wr),
      .full   (q_full),
      .pop    (q_pop),
      .empty  (q_empty),
      .rd_cmd (cmd_rd)
   );

   xdrf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (cmd_rd),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .rsp     (rsp)
   );

   // Drive result ports from the head word
   assign rsp_wrote      = rsp.wrote;
   assign rsp_word_slot  = rsp.word_slot;
   assign rsp_word_value = rsp.word_value;
   assign rsp_frame_end  = rsp.frame_end;
   assign rsp_overrun    = rsp.overrun;

endmodule

// ===== bench/tb_xor_delta_run_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_xor_delta_run_frame_decoder_unit
// Self-checking bench for the XOR delta run frame decoder. Stream and clear
// words go in through the request queue. A bitmap-level model of the decoder
// predicts each response word, and every popped word is compared field by
// field with the oldest prediction. Directed frames hit the boundary cases,
// then random frames run under three idle mixes, with one long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_xor_delta_run_frame_decoder_unit;

   import xdrf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int STALL_CYCLES   = 150;

   // One predicted response word
   typedef struct packed {
      logic        wrote;
      logic [7:0]  word_slot;
      logic [15:0] word_value;
      logic        frame_end;
      logic        overrun;
   } decode_result_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        push          = 1'b0;
   logic        full;
   logic        req_op        = OP_STREAM;
   logic [15:0] req_data_word = '0;
   logic        empty;
   logic        pop           = 1'b0;
   logic        rsp_wrote;
   logic [7:0]  rsp_word_slot;
   logic [15:0] rsp_word_value;
   logic        rsp_frame_end;
   logic        rsp_overrun;

   // Model state of the decoder
   logic [15:0] bitmap_image [BITMAP_DEPTH];
   logic [15:0] model_position;
   logic [15:0] model_frame_left;
   logic [14:0] model_run_left;
   phase_type   model_phase;

   decode_result_type pending_results [$];
   decode_result_type seen_result;
   decode_result_type want_result;

   int fail_count     = 0;
   int quiet_cycles   = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int rsp_hold_count = 0;

   xor_delta_run_frame_decoder_unit uut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_op         (req_op),
      .req_data_word  (req_data_word),
      .empty          (empty),
      .pop            (pop),
      .rsp_wrote      (rsp_wrote),
      .rsp_word_slot  (rsp_word_slot),
      .rsp_word_value (rsp_word_value),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_overrun    (rsp_overrun)
   );

   always #5 clock = ~clock;

   // Wipe the model bitmap and parser back to the header wait
   function automatic void clear_model();
      foreach (bitmap_image[i]) bitmap_image[i] = '0;
      model_position   = '0;
      model_frame_left = '0;
      model_run_left   = '0;
      model_phase      = PH_HEADER;
   endfunction

   // Advance a position, pinning it at the top of the 16-bit range
   function automatic logic [15:0] advance_position(logic [15:0] p, logic [15:0] step);
      logic [16:0] total;
      total = {1'b0, p} + {1'b0, step};
      return total[16] ? 16'hFFFF : total[15:0];
   endfunction

   // Decode one word against the model and return the response it yields
   function automatic decode_result_type predict_decode(logic op, logic [15:0] w);
      decode_result_type r;
      r = '0;
      if (op == OP_CLEAR) begin
         clear_model();
      end else if (model_phase == PH_TOKEN || model_phase == PH_RUN) begin
         model_frame_left = model_frame_left - 16'd1;
         if (model_phase == PH_TOKEN) begin
            if (w[15]) begin
               model_run_left = w[14:0];
               if (w[14:0] != '0) model_phase = PH_RUN;
            end else begin
               model_position = advance_position(model_position, {1'b0, w[14:0]});
            end
         end else begin
            model_run_left = model_run_left - 15'd1;
            if (model_position < BITMAP_DEPTH) begin
               bitmap_image[model_position] = bitmap_image[model_position] ^ w;
               r.wrote      = 1'b1;
               r.word_slot  = model_position[7:0];
               r.word_value = bitmap_image[model_position];
            end else begin
               r.overrun = 1'b1;
            end
            model_position = advance_position(model_position, 16'd1);
            if (model_run_left == '0) model_phase = PH_TOKEN;
         end
         // Close the frame; a run still open is cut short
         if (model_frame_left == '0) begin
            r.frame_end = 1'b1;
            if (model_phase == PH_RUN) r.overrun = 1'b1;
            model_run_left = '0;
            model_phase    = PH_HEADER;
         end
      end else begin
         model_frame_left = w;
         model_position   = '0;
         model_run_left   = '0;
         if (w == '0) begin
            r.frame_end = 1'b1;
            model_phase = PH_HEADER;
         end else begin
            model_phase = PH_TOKEN;
         end
      end
      return r;
   endfunction

   // Offer one word, hold it until the decoder takes it, then predict
   task automatic send_word(input logic op, input logic [15:0] w);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      push          <= 1'b1;
      req_op        <= op;
      req_data_word <= w;
      do @(posedge clock); while (full);
      pending_results.push_back(predict_decode(op, w));
   endtask

   // Drop push and hold off until every predicted word has been popped
   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Build and send one random frame; a few are cut, padded or aborted
   task automatic send_random_frame(output int sent);
      logic [15:0] body [$];
      logic [15:0] header;
      int          run_len;
      sent = 0;
      if ($urandom_range(0, 29) == 0) begin
         send_word(OP_CLEAR, 16'($urandom));
         sent++;
      end
      if ($urandom_range(0, 19) == 0) begin
         send_word(logic'($urandom_range(0, 1)), 16'($urandom));
         sent++;
      end
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       body.push_back({1'b0, 15'($urandom)});
               1, 2:    body.push_back(16'($urandom_range(150, 200)));
               default: body.push_back(16'($urandom_range(0, 40)));
            endcase
         end else begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30)
                                                  : $urandom_range(0, 6);
            body.push_back(16'h8000 | 16'(run_len));
            repeat (run_len) body.push_back(16'($urandom));
         end
      end
      case ($urandom_range(0, 29))
         0, 1:    header = 16'($urandom_range(0, body.size()));
         2:       header = 16'(body.size() + $urandom_range(1, 3));
         default: header = 16'(body.size());
      endcase
      send_word(OP_STREAM, header);
      sent++;
      foreach (body[i]) begin
         // Abort the frame now and then with a clear
         if ($urandom_range(0, 149) == 0) begin
            send_word(OP_CLEAR, 16'($urandom));
            sent++;
            return;
         end
         send_word(OP_STREAM, body[i]);
         sent++;
      end
   endtask

   task automatic test_random_frames(input int target);
      int total;
      int sent;
      total = 0;
      while (total < target) begin
         send_random_frame(sent);
         total += sent;
      end
      wait_drained();
   endtask

   // Boundary frames: empty frame and run, last word, drop past the end,
   // cut-short run, saturating position, clear between frames
   task automatic test_directed_cases();
      send_word(OP_CLEAR, 16'hFFFF);
      send_word(OP_STREAM, 16'h0000);
      send_word(OP_STREAM, 16'd5);
      send_word(OP_STREAM, 16'h8002);
      send_word(OP_STREAM, 16'hFFFF);
      send_word(OP_STREAM, 16'h0001);
      send_word(OP_STREAM, 16'h8000);
      send_word(OP_STREAM, 16'd189);
      send_word(OP_STREAM, 16'd4);
      send_word(OP_STREAM, 16'd191);
      send_word(OP_STREAM, 16'h8003);
      send_word(OP_STREAM, 16'hA5A5);
      send_word(OP_STREAM, 16'h5A5A);
      send_word(OP_STREAM, 16'd5);
      send_word(OP_STREAM, 16'h7FFF);
      send_word(OP_STREAM, 16'h7FFF);
      send_word(OP_STREAM, 16'h0001);
      send_word(OP_STREAM, 16'h8001);
      send_word(OP_STREAM, 16'h1234);
      send_word(OP_STREAM, 16'd3);
      send_word(OP_STREAM, 16'h7FFF);
      send_word(OP_STREAM, 16'd2);
      send_word(OP_STREAM, 16'h8001);
      send_word(OP_CLEAR, 16'h0000);
      send_word(OP_STREAM, 16'hFFFF);
      wait_drained();
   endtask

   // Stall the response side long enough to fill the decoder and block push
   task automatic test_response_stall();
      int saved_idle;
      int total;
      int sent;
      saved_idle     = req_idle_pct;
      req_idle_pct   = 0;
      rsp_hold_count = STALL_CYCLES;
      total          = 0;
      while (total < 40) begin
         send_random_frame(sent);
         total += sent;
      end
      req_idle_pct = saved_idle;
      wait_drained();
   endtask

   // Send a frame, wait for every response, then send another
   task automatic test_pause_until_drained();
      int sent;
      send_random_frame(sent);
      wait_drained();
      send_random_frame(sent);
      wait_drained();
   endtask

   // Response side: random pops, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rsp_hold_count > 0) begin
         pop <= 1'b0;
         rsp_hold_count--;
      end else begin
         pop <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Compare each popped word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         seen_result = '{rsp_wrote, rsp_word_slot, rsp_word_value,
                         rsp_frame_end, rsp_overrun};
         if (pending_results.size() == 0) begin
            $display("%0t: response word with nothing expected, actual %0h",
                     $time, seen_result);
            fail_count++;
         end else begin
            want_result = pending_results.pop_front();
            check_field("wrote", 16'(want_result.wrote), 16'(seen_result.wrote));
            check_field("word_slot", 16'(want_result.word_slot),
                        16'(seen_result.word_slot));
            check_field("word_value", want_result.word_value, seen_result.word_value);
            check_field("frame_end", 16'(want_result.frame_end),
                        16'(seen_result.frame_end));
            check_field("overrun", 16'(want_result.overrun), 16'(seen_result.overrun));
         end
      end
   end

   // Watchdog: end the run when no word moves on either side for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d responses outstanding", $time,
                     pending_results.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      clear_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();

      req_idle_pct = 9;
      rsp_idle_pct = 84;
      test_random_frames(490);
      test_response_stall();

      req_idle_pct = 84;
      rsp_idle_pct = 9;
      test_random_frames(490);
      test_pause_until_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_frames(490);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
